// ===== src/blcp_pkg.sv =====
// Package for the binomial lattice call pricer.
// Holds sizing constants, fixed-point constants, register indexes and the
// command and status structs shared by the controller, datapath and top level.
package blcp_pkg;

  localparam int MAX_STEPS  = 256;
  localparam int NODE_DEPTH = MAX_STEPS + 1;
  localparam int ADDR_W     = $clog2(NODE_DEPTH);
  localparam int PIPE_LAT   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PRICE_W    = 32;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF = 31'h2000_0000;

  localparam logic [8:0]  STEP_COUNT_RST = 9'd5;
  localparam logic [31:0] LOW_FACTOR_RST = 32'h4000_0000;
  localparam logic [31:0] UD_RATIO_RST   = 32'h4000_0000;
  localparam logic [30:0] UP_PROB_RST    = 31'h2000_0000;
  localparam logic [30:0] DISCOUNT_RST   = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT    = 3'd0,
    CFG_LOWEST_FACTOR = 3'd1,
    CFG_UP_DOWN_RATIO = 3'd2,
    CFG_UP_PROB       = 3'd3,
    CFG_STEP_DISCOUNT = 3'd4
  } cfg_reg_t;

  typedef logic [ADDR_W-1:0] node_addr_t;

  // The work that the controller orders in a cycle.
  typedef struct packed {
    logic       load;        // capture a new word and clear the sticky flag
    logic       term_en;     // issue a terminal-price multiply
    logic       term_first;  // terminal multiply uses spot and lowest factor
    logic       rd_en;       // read one node for backward induction
    logic       lvl_first;   // this read opens a level and yields no result
    logic       emit;        // load the result register
    node_addr_t addr;        // read address, or write address of a terminal node
  } cmd_t;

  typedef struct packed {
    node_addr_t steps;       // lattice periods after clipping
    logic       out_free;    // the result register can take a new word
  } sts_t;

endpackage

// ===== src/blcp_quote_if.sv =====
// Input channel of the binomial lattice call pricer: one quote per word.
// Depends on nothing.
interface blcp_quote_if;
  logic        valid;
  logic        ready;
  logic [31:0] spot_price;
  logic [31:0] strike_price;

  modport source (output valid, output spot_price, output strike_price, input ready);
  modport sink (input valid, input spot_price, input strike_price, output ready);
endinterface

// ===== src/blcp_price_if.sv =====
// Output channel of the binomial lattice call pricer: one call price per word.
// Depends on nothing.
interface blcp_price_if;
  logic        valid;
  logic        ready;
  logic [31:0] call_price;
  logic        saturated;

  modport source (output valid, output call_price, output saturated, input ready);
  modport sink (input valid, input call_price, input saturated, output ready);
endinterface

// ===== src/blcp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module blcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/blcp_ctrl.sv =====
// Controller of the binomial lattice call pricer: sequences the terminal
// sweep, the backward levels, pipeline gaps and result hand-off.
// Depends on blcp_pkg.
module blcp_ctrl
  import blcp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(PIPE_LAT);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_TERM_MUL = 7'b0000010,
    ST_TERM_WR  = 7'b0000100,
    ST_RUN      = 7'b0001000,
    ST_GAP      = 7'b0010000,
    ST_DRAIN    = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  node_addr_t       lvl, lvl_next;
  node_addr_t       idx, idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lvl   <= '0;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    idx_next   = idx;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = ST_TERM_MUL;
        end
      end
      ST_TERM_MUL: begin
        cmd.term_en    = 1'b1;
        cmd.term_first = (idx == '0);
        cmd.addr       = idx;
        state_next     = ST_TERM_WR;
      end
      ST_TERM_WR: begin
        if (idx == sts.steps) begin
          if (sts.steps == '0) begin
            state_next = ST_FINISH;
          end else begin
            lvl_next   = sts.steps;
            idx_next   = '0;
            state_next = ST_RUN;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_TERM_MUL;
        end
      end
      ST_RUN: begin
        cmd.rd_en     = 1'b1;
        cmd.lvl_first = (idx == '0);
        cmd.addr      = idx;
        if (idx == lvl) begin
          idx_next = '0;
          if (lvl == node_addr_t'(1)) begin
            cnt_next   = CNT_W'(PIPE_LAT - 1);
            state_next = ST_DRAIN;
          end else begin
            lvl_next = lvl - 1'b1;
            // Short levels would read a node before its new value lands.
            if (32'(lvl) <= 32'(PIPE_LAT)) begin
              cnt_next   = CNT_W'(32'(PIPE_LAT) - 32'(lvl));
              state_next = ST_GAP;
            end
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_GAP: begin
        if (cnt == '0) begin
          state_next = ST_RUN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/blcp_dp.sv =====
// Datapath of the binomial lattice call pricer: configuration registers,
// the mixing pipeline, the shared price-scaling multiplier and the result register.
// Depends on blcp_pkg.
module blcp_dp
  import blcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]           spot_price,
  input  logic [31:0]           strike_price,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  ram_we,
  output node_addr_t            ram_waddr,
  output logic [PRICE_W-1:0]    ram_wdata,
  input  logic [PRICE_W-1:0]    ram_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           call_price,
  output logic                  saturated
);

  logic [8:0]  step_count;
  logic [31:0] lowest_node_factor;
  logic [31:0] up_down_ratio;
  logic [30:0] up_probability;
  logic [30:0] step_discount;

  logic [31:0] spot_reg;
  logic [31:0] strike_reg;
  logic [30:0] q_reg;
  logic        sat_reg;
  logic [31:0] price_reg;
  logic [31:0] root_reg;

  logic               p1_valid, p1_prod;
  node_addr_t         p1_addr;
  logic [31:0]        lower_reg;
  logic               p2_valid;
  node_addr_t         p2_addr;
  logic [31:0]        lower_d;
  logic signed [64:0] mix_prod;
  logic               p3_valid;
  node_addr_t         p3_addr;
  logic [31:0]        avg_reg;
  logic               p4_valid, p4_term;
  node_addr_t         p4_addr;
  logic [63:0]        scale_prod;

  logic [30:0]        q_eff;
  logic signed [32:0] diff;
  logic signed [65:0] mix_sum;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        rounded;
  logic [33:0]        scale_hi;
  logic               ovf;
  logic [31:0]        scaled, payoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count         <= STEP_COUNT_RST;
      lowest_node_factor <= LOW_FACTOR_RST;
      up_down_ratio      <= UD_RATIO_RST;
      up_probability     <= UP_PROB_RST;
      step_discount      <= DISCOUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STEP_COUNT:    step_count         <= cfg_data[8:0];
        CFG_LOWEST_FACTOR: lowest_node_factor <= cfg_data[31:0];
        CFG_UP_DOWN_RATIO: up_down_ratio      <= cfg_data[31:0];
        CFG_UP_PROB:       up_probability     <= cfg_data[30:0];
        CFG_STEP_DISCOUNT: step_discount      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign q_eff = (up_probability > Q30_ONE) ? Q30_ONE : up_probability;

  assign sts.steps = (32'(step_count) > 32'(MAX_STEPS)) ? ADDR_W'(MAX_STEPS)
                                                         : ADDR_W'(step_count);
  assign sts.out_free = !out_valid || out_ready;

  // Mixing rewritten as lower*2^30 + q*(upper - lower): one multiplier.
  assign diff    = $signed({1'b0, ram_rdata}) - $signed({1'b0, lower_reg});
  assign mix_sum = $signed({4'b0, lower_d, 30'b0}) + 66'(mix_prod)
                 + $signed(66'(Q30_HALF));

  always_comb begin
    if (cmd.term_en) begin
      mul_a = cmd.term_first ? spot_reg : price_reg;
      mul_b = cmd.term_first ? lowest_node_factor : up_down_ratio;
    end else begin
      mul_a = avg_reg;
      mul_b = {1'b0, step_discount};
    end
  end

  assign rounded  = scale_prod + 64'(Q30_HALF);
  assign scale_hi = rounded[63:30];
  assign ovf      = |scale_hi[33:32];
  assign scaled   = ovf ? '1 : scale_hi[31:0];
  assign payoff   = (scaled > strike_reg) ? scaled - strike_reg : '0;

  assign ram_we    = p4_valid;
  assign ram_waddr = p4_addr;
  assign ram_wdata = p4_term ? payoff : scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p1_prod  <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      sat_reg  <= 1'b0;
    end else begin
      p1_valid <= cmd.rd_en;
      p1_prod  <= cmd.rd_en && !cmd.lvl_first;
      p2_valid <= p1_prod;
      p3_valid <= p2_valid;
      p4_valid <= cmd.term_en || p3_valid;
      if (cmd.load) begin
        sat_reg <= 1'b0;
      end else if (p4_valid && ovf) begin
        sat_reg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spot_reg   <= spot_price;
      strike_reg <= strike_price;
      q_reg      <= q_eff;
    end
    p1_addr <= cmd.addr;
    if (p1_valid) begin
      lower_reg <= ram_rdata;
    end
    if (p1_prod) begin
      mix_prod <= $signed({1'b0, q_reg}) * diff;
      lower_d  <= lower_reg;
      p2_addr  <= p1_addr - 1'b1;
    end
    if (p2_valid) begin
      avg_reg <= mix_sum[61:30];
      p3_addr <= p2_addr;
    end
    if (cmd.term_en || p3_valid) begin
      scale_prod <= mul_a * mul_b;
      p4_term    <= cmd.term_en;
      p4_addr    <= cmd.term_en ? cmd.addr : p3_addr;
    end
    if (p4_valid) begin
      if (p4_term) begin
        price_reg <= scaled;
      end
      if (p4_addr == '0) begin
        root_reg <= ram_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      call_price <= root_reg;
      saturated  <= sat_reg;
    end
  end

endmodule

// ===== src/binomial_lattice_call_pricer.sv =====
// Top level of the binomial lattice call pricer (Cox-Ross-Rubinstein, European call).
// Depends on blcp_pkg, blcp_quote_if, blcp_price_if, blcp_ram, blcp_ctrl and blcp_dp.
//
//   Channel  Dir  Handshake          Word contents
//   -------  ---  -----------------  ---------------------------------------------
//   quote    in   valid/ready        spot_price, strike_price (unsigned Q16.16)
//   price    out  valid/ready        call_price (unsigned Q16.16), saturated
//   cfg      in   cfg_we only        cfg_index selects register, cfg_data value
//
// With n lattice periods, a word passes through the terminal sweep, the backward
// induction levels, gaps on the last short levels, the pipeline drain and the
// result hand-off. The single read port of the node RAM, one node per cycle
// outside the gaps, bounds the backward induction.
// Reset is synchronous and active high; the node RAM is not cleared.
// The block takes one quote at a time; a finished result waits in its own
// register, so a new quote is accepted while the price channel stalls.
module binomial_lattice_call_pricer
  import blcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  blcp_quote_if.sink            quote,
  blcp_price_if.source          price,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t                 cmd;
  sts_t                 sts;
  logic                 ram_we;
  node_addr_t           ram_waddr;
  logic [PRICE_W-1:0]   ram_wdata;
  logic [PRICE_W-1:0]   ram_rdata;

  // The controller walks the lattice: each terminal node takes a multiply state
  // and a write state because each price feeds the next multiply, then each
  // level is streamed through the mixing pipeline one node per cycle.
  blcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (quote.valid),
    .in_ready (quote.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns configuration, the arithmetic pipeline and the result
  // register. Reads go straight from the controller's command to the RAM.
  blcp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .spot_price   (quote.spot_price),
    .strike_price (quote.strike_price),
    .cmd          (cmd),
    .sts          (sts),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata),
    .out_valid    (price.valid),
    .out_ready    (price.ready),
    .call_price   (price.call_price),
    .saturated    (price.saturated)
  );

  // Node values of the current lattice level, lowest node at address zero.
  blcp_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (ram_rdata)
  );

  // Only one quote is in flight: the controller drops ready once it takes one.
  a_one_quote: assert property (@(posedge clk) disable iff (rst)
    (quote.valid && quote.ready) |=> !quote.ready)
    else $error("quote accepted while a previous one is in work");

  // Level gaps must keep a node read away from a pending write to it.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && cmd.rd_en) |-> (ram_waddr != cmd.addr))
    else $error("node read and write at the same address");

  // A result is only loaded when the pipeline has drained.
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !ram_we)
    else $error("result taken while node writes are pending");

  // A result is only loaded when the previous one has gone or is going.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!price.valid || price.ready))
    else $error("result register overwritten before it was taken");

endmodule
